// File: hw/rtl/gdc_pkg.sv
// Shared types, constants and codes for the gesture direction classifier.
// No dependencies; every other file in hw/rtl imports this package.
package gdc_pkg;

  localparam int MAX_DATASETS = 32;
  localparam int MIN_DATASETS = 5;
  localparam int ACCUM_W      = 16;
  localparam int RATIO_SCALE  = 100;
  localparam int CNT_W        = 6;
  localparam int DIV_STEPS    = 15;
  localparam int QDEPTH       = 2;

  typedef enum logic [2:0] {
    CFG_OUT_THRESHOLD     = 3'd0,
    CFG_SWIPE_SENSITIVITY = 3'd1,
    CFG_STILL_SENSITIVITY = 3'd2,
    CFG_NEAR_NEEDED       = 3'd3,
    CFG_FAR_NEEDED        = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MOT_NONE  = 3'd0,
    MOT_UP    = 3'd1,
    MOT_DOWN  = 3'd2,
    MOT_LEFT  = 3'd3,
    MOT_RIGHT = 3'd4,
    MOT_NEAR  = 3'd5,
    MOT_FAR   = 3'd6
  } motion_e;

  typedef enum logic [1:0] {
    PROX_NONE = 2'd0,
    PROX_NEAR = 2'd1,
    PROX_FAR  = 2'd2
  } prox_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_DEC,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic       req_type;
    logic [7:0] up_value;
    logic [7:0] down_value;
    logic [7:0] left_value;
    logic [7:0] right_value;
    logic       batch_last;
  } in_item_t;

  typedef struct packed {
    logic       is_final;
    logic       batch_processed;
    logic [2:0] motion;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  out_threshold;
    logic [14:0] swipe_sensitivity;
    logic [7:0]  still_sensitivity;
    logic [7:0]  near_needed;
    logic [7:0]  far_needed;
  } cfg_t;

  // One job for the back end: a closed batch or the end of a gesture.
  typedef struct packed {
    logic        is_final;
    logic        process;
    logic [31:0] first_sample;
    logic [31:0] last_sample;
  } cmd_t;

endpackage

// File: hw/rtl/gdc_front.sv
// Front end: accepts datasets, tracks the batch and its qualifying samples.
// Depends on gdc_pkg; feeds gdc_queue with one job per batch end or gesture end.
module gdc_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  gdc_pkg::in_item_t in_data_i,
  output logic            in_stall_o,
  input  logic [7:0]      out_threshold_i,
  input  logic            q_full_i,
  output logic            push_o,
  output gdc_pkg::cmd_t   cmd_o
);
  import gdc_pkg::*;

  localparam logic [CNT_W-1:0] CntMax = {CNT_W{1'b1}};

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             found_q, found_d;
  logic [31:0]      first_q, first_d, last_q, last_d;
  logic             accept, qualify;
  logic [31:0]      packed_s;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  assign qualify = (in_data_i.up_value > out_threshold_i) &&
                   (in_data_i.down_value > out_threshold_i) &&
                   (in_data_i.left_value > out_threshold_i) &&
                   (in_data_i.right_value > out_threshold_i);
  assign packed_s = {in_data_i.right_value, in_data_i.left_value,
                     in_data_i.down_value, in_data_i.up_value};

  always_comb begin
    cnt_d   = (cnt_q == CntMax) ? cnt_q : cnt_q + 1'b1;
    found_d = found_q;
    first_d = first_q;
    last_d  = last_q;
    if (qualify) begin
      if (!found_q) begin
        first_d = packed_s;
      end
      found_d = 1'b1;
      last_d  = packed_s;
    end
  end

  assign push_o = accept && (in_data_i.req_type || in_data_i.batch_last);

  always_comb begin
    cmd_o.is_final     = in_data_i.req_type;
    cmd_o.process      = !in_data_i.req_type && found_d &&
                         (cnt_d >= CNT_W'(MIN_DATASETS)) &&
                         (cnt_d <= CNT_W'(MAX_DATASETS));
    cmd_o.first_sample = first_d;
    cmd_o.last_sample  = last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      found_q <= 1'b0;
      first_q <= '0;
      last_q  <= '0;
    end else if (accept) begin
      if (in_data_i.req_type || in_data_i.batch_last) begin
        cnt_q   <= '0;
        found_q <= 1'b0;
        first_q <= '0;
        last_q  <= '0;
      end else begin
        cnt_q   <= cnt_d;
        found_q <= found_d;
        first_q <= first_d;
        last_q  <= last_d;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> (first_q != '0 && last_q != '0))
    else $error("found flag set without stored samples");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.req_type) |=> (cnt_q == '0 && !found_q))
    else $error("gesture end did not clear batch");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> !q_full_i)
    else $error("push into full queue");

endmodule

// File: hw/rtl/gdc_queue.sv
// Two-entry job queue between front and back end.
// Depends on gdc_pkg for the job type.
module gdc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gdc_pkg::cmd_t push_data_i,
  input  logic          pop_i,
  output gdc_pkg::cmd_t pop_data_o,
  output logic          full_o,
  output logic          empty_o
);
  import gdc_pkg::*;

  localparam int PtrW = $clog2(QDEPTH);

  cmd_t            mem_q [QDEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;

  assign full_o     = (cnt_q == (PtrW+1)'(QDEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PtrW+1)'(QDEPTH))
    else $error("queue overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("pop from empty queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("queue count lost a push");

endmodule

// File: hw/rtl/gdc_back.sv
// Back end: ratio division, accumulation, near/far tracking and motion decode.
// Depends on gdc_pkg; takes jobs from gdc_queue and drives the result register.
module gdc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gdc_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  gdc_pkg::cmd_t      q_data_i,
  output logic               pop_o,
  output logic               out_valid_o,
  output gdc_pkg::out_item_t out_data_o,
  input  logic               out_stall_i
);
  import gdc_pkg::*;

  localparam int CmpW = ((ACCUM_W > 15) ? ACCUM_W : 15) + 2;
  localparam logic signed [ACCUM_W:0] AccHi = (ACCUM_W+1)'((64'sd1 <<< (ACCUM_W-1)) - 1);
  localparam logic signed [ACCUM_W:0] AccLo = -AccHi - 1;

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [1:0]  idx_q;
  logic [3:0]  step_q;
  logic [14:0] dv_q;
  logic [8:0]  rem_q, den_q;
  logic        neg_q;
  logic signed [7:0] ratio_q [4];

  logic signed [ACCUM_W-1:0] ud_acc_q, lr_acc_q;
  dir_e        ud_dir_q, lr_dir_q;
  logic [7:0]  near_q, far_q;
  prox_e       prox_q;
  motion_e     motion_q;
  out_item_t   out_q;
  logic        out_valid_q;

  // Control strobes.
  logic start, div_step, div_last, do_upd, do_dec, do_out, out_free;

  assign out_free = !out_valid_q || !out_stall_i;
  assign div_last = (step_q == 4'(DIV_STEPS - 1));

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          if (q_data_i.is_final) state_d = ST_DEC;
          else if (q_data_i.process) state_d = ST_DIV;
          else state_d = ST_OUT;
        end
      end
      ST_DIV: if (div_last && idx_q == 2'd3) state_d = ST_UPD;
      ST_UPD: state_d = ST_DEC;
      ST_DEC: state_d = ST_OUT;
      ST_OUT: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    start    = (state_q == ST_IDLE) && !q_empty_i;
    div_step = (state_q == ST_DIV);
    do_upd   = (state_q == ST_UPD);
    do_dec   = (state_q == ST_DEC);
    do_out   = (state_q == ST_OUT) && out_free;
  end

  assign pop_o = start;

  // Operand load: order is last up/down, first up/down, last left/right, first left/right.
  logic [1:0]  ld_idx;
  logic [31:0] ld_smp;
  logic [7:0]  ld_a, ld_b, ld_mag;
  always_comb begin
    ld_idx = start ? 2'd0 : idx_q + 2'd1;
    if (start) ld_smp = q_data_i.last_sample;
    else ld_smp = ld_idx[0] ? cmd_q.first_sample : cmd_q.last_sample;
    ld_a   = ld_idx[1] ? ld_smp[23:16] : ld_smp[7:0];
    ld_b   = ld_idx[1] ? ld_smp[31:24] : ld_smp[15:8];
    ld_mag = (ld_a >= ld_b) ? ld_a - ld_b : ld_b - ld_a;
  end

  // One restoring division step per cycle.
  logic [9:0]  trial;
  logic        ge;
  logic [8:0]  rem_n;
  logic [14:0] q_fin;
  logic signed [7:0] ratio_val;
  always_comb begin
    trial = {rem_q, dv_q[14]};
    ge    = trial >= {1'b0, den_q};
    rem_n = ge ? 9'(trial - {1'b0, den_q}) : trial[8:0];
    q_fin = {dv_q[13:0], ge};
    if (den_q == '0) ratio_val = '0;
    else if (neg_q) ratio_val = -$signed(q_fin[7:0]);
    else ratio_val = $signed(q_fin[7:0]);
  end

  // Batch update.
  logic signed [8:0] ud_d, lr_d;
  logic [7:0]  ud_mag, lr_mag;
  logic signed [ACCUM_W:0]   ud_sum, lr_sum;
  logic signed [ACCUM_W-1:0] ud_acc_n, lr_acc_n;
  logic signed [CmpW-1:0]    sens_s;
  dir_e        ud_dir_n, lr_dir_n;
  logic [7:0]  near_n, far_n;
  prox_e       prox_n;
  logic        both_zero;
  always_comb begin
    ud_d = 9'(ratio_q[0]) - 9'(ratio_q[1]);
    lr_d = 9'(ratio_q[2]) - 9'(ratio_q[3]);
    ud_mag = ud_d[8] ? 8'(-ud_d) : ud_d[7:0];
    lr_mag = lr_d[8] ? 8'(-lr_d) : lr_d[7:0];
    both_zero = (ud_d == '0) && (lr_d == '0);
    ud_sum = (ACCUM_W+1)'(ud_acc_q) + (ACCUM_W+1)'(ud_d);
    lr_sum = (ACCUM_W+1)'(lr_acc_q) + (ACCUM_W+1)'(lr_d);
    if (ud_sum > AccHi) ud_sum = AccHi;
    if (ud_sum < AccLo) ud_sum = AccLo;
    if (lr_sum > AccHi) lr_sum = AccHi;
    if (lr_sum < AccLo) lr_sum = AccLo;
    ud_acc_n = ud_sum[ACCUM_W-1:0];
    lr_acc_n = lr_sum[ACCUM_W-1:0];
    sens_s   = $signed(CmpW'(cfg_i.swipe_sensitivity));
    if (CmpW'(ud_acc_n) >= sens_s) ud_dir_n = DIR_POS;
    else if (CmpW'(ud_acc_n) <= -sens_s) ud_dir_n = DIR_NEG;
    else ud_dir_n = DIR_NONE;
    if (CmpW'(lr_acc_n) >= sens_s) lr_dir_n = DIR_POS;
    else if (CmpW'(lr_acc_n) <= -sens_s) lr_dir_n = DIR_NEG;
    else lr_dir_n = DIR_NONE;
    near_n = near_q;
    far_n  = far_q;
    prox_n = prox_q;
    if (ud_mag < cfg_i.still_sensitivity && lr_mag < cfg_i.still_sensitivity) begin
      if (ud_dir_n == DIR_NONE && lr_dir_n == DIR_NONE) begin
        if (both_zero) near_n = (near_q == 8'hFF) ? near_q : near_q + 1'b1;
        else far_n = (far_q == 8'hFF) ? far_q : far_q + 1'b1;
        if (near_n >= cfg_i.near_needed && far_n >= cfg_i.far_needed) begin
          if (both_zero) prox_n = PROX_NEAR;
          else if (ud_d != '0 && lr_d != '0) prox_n = PROX_FAR;
        end
      end else begin
        if (both_zero) near_n = (near_q == 8'hFF) ? near_q : near_q + 1'b1;
        if (near_n >= cfg_i.near_needed) begin
          ud_dir_n = DIR_NONE;
          lr_dir_n = DIR_NONE;
          ud_acc_n = '0;
          lr_acc_n = '0;
        end
      end
    end
  end

  // Motion decode.
  logic [ACCUM_W:0] ud_abs, lr_abs;
  logic             ud_wins;
  motion_e          motion_n;
  always_comb begin
    ud_abs  = ud_acc_q[ACCUM_W-1] ? (ACCUM_W+1)'(-(ACCUM_W+1)'(ud_acc_q))
                                  : (ACCUM_W+1)'(ud_acc_q);
    lr_abs  = lr_acc_q[ACCUM_W-1] ? (ACCUM_W+1)'(-(ACCUM_W+1)'(lr_acc_q))
                                  : (ACCUM_W+1)'(lr_acc_q);
    ud_wins = ud_abs > lr_abs;
    motion_n = motion_q;
    if (prox_q == PROX_NEAR) motion_n = MOT_NEAR;
    else if (prox_q == PROX_FAR) motion_n = MOT_FAR;
    else if (ud_dir_q == DIR_NEG && lr_dir_q == DIR_NONE) motion_n = MOT_UP;
    else if (ud_dir_q == DIR_POS && lr_dir_q == DIR_NONE) motion_n = MOT_DOWN;
    else if (ud_dir_q == DIR_NONE && lr_dir_q == DIR_POS) motion_n = MOT_RIGHT;
    else if (ud_dir_q == DIR_NONE && lr_dir_q == DIR_NEG) motion_n = MOT_LEFT;
    else if (ud_dir_q == DIR_NEG && lr_dir_q == DIR_POS) motion_n = ud_wins ? MOT_UP : MOT_RIGHT;
    else if (ud_dir_q == DIR_POS && lr_dir_q == DIR_NEG) motion_n = ud_wins ? MOT_DOWN : MOT_LEFT;
    else if (ud_dir_q == DIR_NEG && lr_dir_q == DIR_NEG) motion_n = ud_wins ? MOT_UP : MOT_LEFT;
    else if (ud_dir_q == DIR_POS && lr_dir_q == DIR_POS) motion_n = ud_wins ? MOT_DOWN : MOT_RIGHT;
  end

  // Divider and job registers.
  always_ff @(posedge clk_i) begin
    if (start) begin
      cmd_q <= q_data_i;
    end
    if (start || (div_step && div_last && idx_q != 2'd3)) begin
      dv_q  <= 15'(ld_mag) * 15'(RATIO_SCALE);
      rem_q <= '0;
      den_q <= 9'(ld_a) + 9'(ld_b);
      neg_q <= ld_a < ld_b;
    end else if (div_step) begin
      dv_q  <= q_fin;
      rem_q <= rem_n;
    end
    if (div_step && div_last) begin
      ratio_q[idx_q] <= ratio_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      step_q      <= '0;
      ud_acc_q    <= '0;
      lr_acc_q    <= '0;
      ud_dir_q    <= DIR_NONE;
      lr_dir_q    <= DIR_NONE;
      near_q      <= '0;
      far_q       <= '0;
      prox_q      <= PROX_NONE;
      motion_q    <= MOT_NONE;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (start) begin
        idx_q  <= '0;
        step_q <= '0;
      end else if (div_step) begin
        step_q <= div_last ? '0 : step_q + 1'b1;
        if (div_last) idx_q <= idx_q + 2'd1;
      end
      if (do_upd) begin
        ud_acc_q <= ud_acc_n;
        lr_acc_q <= lr_acc_n;
        ud_dir_q <= ud_dir_n;
        lr_dir_q <= lr_dir_n;
        near_q   <= near_n;
        far_q    <= far_n;
        prox_q   <= prox_n;
      end
      if (do_dec) motion_q <= motion_n;
      // Drop the result once taken, unless a new one loads in the same cycle.
      if (!do_out && !out_stall_i) out_valid_q <= 1'b0;
      if (do_out) begin
        out_valid_q           <= 1'b1;
        out_q.is_final        <= cmd_q.is_final;
        out_q.batch_processed <= !cmd_q.is_final && cmd_q.process;
        out_q.motion          <= motion_q;
        if (cmd_q.is_final) begin
          // Drop all gesture state; configuration stays.
          ud_acc_q <= '0;
          lr_acc_q <= '0;
          ud_dir_q <= DIR_NONE;
          lr_dir_q <= DIR_NONE;
          near_q   <= '0;
          far_q    <= '0;
          prox_q   <= PROX_NONE;
          motion_q <= MOT_NONE;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (step_q < 4'(DIV_STEPS)))
    else $error("divider step count out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_step && div_last) |-> (q_fin <= 15'(RATIO_SCALE)))
    else $error("ratio quotient above scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside output state");

endmodule

// File: hw/rtl/gesture_direction_classifier.sv
// Top level of the gesture direction classifier: config registers and wiring.
// Depends on gdc_pkg, gdc_front, gdc_queue and gdc_back.
//
// Feed datasets (up, down, left, right bytes) on the input channel; mark the
// last dataset of each sensor read batch with batch_last, and send an item
// with req_type set when the gesture ends. Every batch end and every gesture
// end yields one result beat; plain datasets yield none. A dataset is taken
// by the front end, which only tracks the batch, so datasets stream in back
// to back while the queue is not full. A processed batch end goes through
// one shared restoring divider for four ratios at one quotient bit per cycle,
// then an update, a decode and a load of the result register. Unprocessed
// batch ends skip all but the load; a gesture end skips the divider and
// update. A two-job queue sits between the front and back ends, so the input
// stalls only when two jobs wait in the queue behind the one in the back end.
// The result register holds a beat while the output is stalled; the back end
// keeps working meanwhile, but its output state waits for a free register.
// Write the configuration registers only while the block is idle; writes to
// indexes beyond far_needed are ignored.
module gesture_direction_classifier (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  gdc_pkg::in_item_t   in_data_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  output gdc_pkg::out_item_t  out_data_o,
  input  logic                out_stall_i,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [14:0]         cfg_wdata_i
);
  import gdc_pkg::*;

  cfg_t cfg_q;
  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, pop_cmd;

  // Configuration registers; hold between writes and across gesture ends.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.out_threshold     <= 8'd10;
      cfg_q.swipe_sensitivity <= 15'd50;
      cfg_q.still_sensitivity <= 8'd20;
      cfg_q.near_needed       <= 8'd10;
      cfg_q.far_needed        <= 8'd2;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OUT_THRESHOLD:     cfg_q.out_threshold     <= cfg_wdata_i[7:0];
        CFG_SWIPE_SENSITIVITY: cfg_q.swipe_sensitivity <= cfg_wdata_i;
        CFG_STILL_SENSITIVITY: cfg_q.still_sensitivity <= cfg_wdata_i[7:0];
        CFG_NEAR_NEEDED:       cfg_q.near_needed       <= cfg_wdata_i[7:0];
        CFG_FAR_NEEDED:        cfg_q.far_needed        <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  gdc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_data_i       (in_data_i),
    .in_stall_o      (in_stall_o),
    .out_threshold_i (cfg_q.out_threshold),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  gdc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (pop_cmd),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  gdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
